// File: hdl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants for the SHA-1 message digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [4:0][31:0]  chain_t;

  localparam int unsigned BLK_WORDS = 16;
  localparam int unsigned ADDR_W    = 4;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hEFCDAB89;
  localparam word_t IV2 = 32'h98BADCFE;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hC3D2E1F0;

  localparam chain_t CHAIN_IV = {IV4, IV3, IV2, IV1, IV0};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic start;
    logic init;
  } cmp_ctl_t;

  typedef struct packed {
    logic  done;
    addr_t rd_addr;
  } cmp_sts_t;

endpackage

// File: hdl/sha1md_ram.sv
// ----------------------------------------------------------------------------
// sha1md_ram
// Message block store: sixteen 32-bit words, one write and one registered
// read port.
// ----------------------------------------------------------------------------
module sha1md_ram
  import sha1md_pkg::*;
(
  input  logic  clk,
  input  logic  wr_en,
  input  addr_t wr_addr,
  input  word_t wr_data,
  input  addr_t rd_addr,
  output word_t rd_data
);

  word_t mem [BLK_WORDS];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/sha1md_core.sv
// ----------------------------------------------------------------------------
// sha1md_core
// Compression engine: one round per cycle, schedule window fed from the
// block store, chaining value update.
// ----------------------------------------------------------------------------
module sha1md_core
  import sha1md_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cmp_ctl_t ctl,
  input  word_t    rd_data,
  output cmp_sts_t sts,
  output chain_t   chain
);

  typedef enum logic [1:0] {E_IDLE, E_RUN, E_ADD} eng_st_t;

  eng_st_t     st_r;
  logic [6:0]  rnd_r;
  chain_t      chain_r;
  word_t       v_r [5];
  word_t       w_r [BLK_WORDS];

  word_t wt;
  word_t wx;
  word_t f;
  word_t k;
  word_t tmp;

  always_comb begin
    wx  = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wt  = (rnd_r < 7'd16) ? rd_data : {wx[30:0], wx[31]};
    if (rnd_r < 7'd20) begin
      f = (v_r[1] & v_r[2]) | (~v_r[1] & v_r[3]);
      k = K0;
    end else if (rnd_r < 7'd40) begin
      f = v_r[1] ^ v_r[2] ^ v_r[3];
      k = K1;
    end else if (rnd_r < 7'd60) begin
      f = (v_r[1] & v_r[2]) | (v_r[1] & v_r[3]) | (v_r[2] & v_r[3]);
      k = K2;
    end else begin
      f = v_r[1] ^ v_r[2] ^ v_r[3];
      k = K3;
    end
    tmp = {v_r[0][26:0], v_r[0][31:27]} + f + v_r[4] + k + wt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= E_IDLE;
      rnd_r   <= '0;
      chain_r <= CHAIN_IV;
    end else begin
      case (st_r)
        E_IDLE: begin
          if (ctl.start) begin
            st_r  <= E_RUN;
            rnd_r <= '0;
          end
          if (ctl.init) begin
            chain_r <= CHAIN_IV;
          end
        end
        E_RUN: begin
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd79) begin
            st_r <= E_ADD;
          end
        end
        E_ADD: begin
          for (int i = 0; i < 5; i++) begin
            chain_r[i] <= chain_r[i] + v_r[i];
          end
          st_r  <= E_IDLE;
          rnd_r <= '0;
        end
        default: begin
          st_r <= E_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == E_IDLE && ctl.start) begin
      for (int i = 0; i < 5; i++) begin
        v_r[i] <= chain_r[i];
      end
    end else if (st_r == E_RUN) begin
      v_r[4] <= v_r[3];
      v_r[3] <= v_r[2];
      v_r[2] <= {v_r[1][1:0], v_r[1][31:2]};
      v_r[1] <= v_r[0];
      v_r[0] <= tmp;
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[BLK_WORDS-1] <= wt;
    end
  end

  assign sts.done    = (st_r == E_ADD);
  assign sts.rd_addr = (st_r == E_RUN) ? (rnd_r[ADDR_W-1:0] + addr_t'(1)) : '0;
  assign chain       = chain_r;

endmodule

// File: hdl/sha1_message_digest_top.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_top
// SHA-1 over a byte stream: block gathering, padding, compression and
// digest serialization.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle while a block fills; each full block
// then holds off the input while it is compressed (80 rounds on the round
// engine plus chain update).
// End of message: padding runs one byte per cycle outside compressions (9
// to 72 bytes, one or two compressions), then 20 digest bytes stream out.
// Reset: synchronous, active low; restores the initial chaining value and
// an empty message. Block store contents are not cleared.
module sha1_message_digest_top
  import sha1md_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] byte_present
  input  logic       in_tlast,   // message_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] digest_byte
  output logic       out_tlast   // digest_last
);

  typedef enum logic [1:0] {S_IN, S_PAD, S_COMP, S_OUT} state_t;

  state_t      state_r;
  state_t      ret_r;
  logic [5:0]  fill_r;
  logic [63:0] bitlen_r;
  logic [63:0] len_r;
  logic [23:0] acc_r;
  logic        pad_80_r;
  logic        len_busy_r;
  logic [4:0]  idx_r;

  logic        acc_in;
  logic        acc_out;
  logic        pb_valid;
  logic [7:0]  pb_byte;
  logic        len_sel;
  logic        blk_full;
  logic        wr_en;
  word_t       rd_data;
  word_t       dword;
  cmp_ctl_t    ctl;
  cmp_sts_t    sts;
  chain_t      chain;

  assign in_tready  = (state_r == S_IN);
  assign out_tvalid = (state_r == S_OUT);
  assign acc_in     = in_tvalid && in_tready;
  assign acc_out    = out_tvalid && out_tready;
  assign out_tlast  = (idx_r == 5'd19);

  assign len_sel = !pad_80_r && (len_busy_r || fill_r == 6'd56);

  always_comb begin
    pb_valid = 1'b0;
    pb_byte  = in_tdata;
    case (state_r)
      S_IN: begin
        pb_valid = acc_in && in_tuser;
      end
      S_PAD: begin
        pb_valid = 1'b1;
        if (pad_80_r) begin
          pb_byte = PAD_BYTE;
        end else if (len_sel) begin
          pb_byte = len_r[63:56];
        end else begin
          pb_byte = 8'h00;
        end
      end
      default: begin
        pb_valid = 1'b0;
      end
    endcase
  end

  assign blk_full = pb_valid && (fill_r == 6'd63);
  assign wr_en    = pb_valid && (fill_r[1:0] == 2'b11);

  assign ctl.start = blk_full;
  assign ctl.init  = acc_out && out_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IN;
      ret_r      <= S_IN;
      fill_r     <= '0;
      bitlen_r   <= '0;
      pad_80_r   <= 1'b0;
      len_busy_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      if (pb_valid) begin
        fill_r <= fill_r + 6'd1;
      end
      case (state_r)
        S_IN: begin
          if (acc_in) begin
            if (in_tuser) begin
              bitlen_r <= bitlen_r + 64'd8;
            end
            if (in_tlast) begin
              pad_80_r   <= 1'b1;
              len_busy_r <= 1'b0;
            end
            if (blk_full) begin
              state_r <= S_COMP;
              ret_r   <= in_tlast ? S_PAD : S_IN;
            end else if (in_tlast) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_80_r <= 1'b0;
          if (len_sel) begin
            len_busy_r <= 1'b1;
          end
          if (blk_full) begin
            state_r <= S_COMP;
            ret_r   <= len_sel ? S_OUT : S_PAD;
          end
        end
        S_COMP: begin
          if (sts.done) begin
            state_r <= ret_r;
          end
        end
        S_OUT: begin
          if (acc_out) begin
            if (out_tlast) begin
              state_r  <= S_IN;
              idx_r    <= '0;
              fill_r   <= '0;
              bitlen_r <= '0;
            end else begin
              idx_r <= idx_r + 5'd1;
            end
          end
        end
        default: begin
          state_r <= S_IN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pb_valid) begin
      acc_r <= {acc_r[15:0], pb_byte};
    end
    if (acc_in && in_tlast) begin
      len_r <= bitlen_r + (in_tuser ? 64'd8 : 64'd0);
    end else if (state_r == S_PAD && len_sel) begin
      len_r <= {len_r[55:0], 8'h00};
    end
  end

  sha1md_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r[5:2]),
    .wr_data ({acc_r, pb_byte}),
    .rd_addr (sts.rd_addr),
    .rd_data (rd_data)
  );

  sha1md_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_data (rd_data),
    .sts     (sts),
    .chain   (chain)
  );

  always_comb begin
    dword = chain[idx_r[4:2]];
    case (idx_r[1:0])
      2'd0:    out_tdata = dword[31:24];
      2'd1:    out_tdata = dword[23:16];
      2'd2:    out_tdata = dword[15:8];
      default: out_tdata = dword[7:0];
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output sides active together");

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == S_COMP))
    else $error("compression finished outside compress state");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_out && out_tlast) |=> (in_tready && fill_r == 6'd0 && bitlen_r == 64'd0))
    else $error("message state not cleared after digest");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> (state_r == S_IN || state_r == S_PAD))
    else $error("compression started while busy");

endmodule
